/* rtl/lpu8_pkg.sv */
package lpu8_pkg;

    localparam int PREFIX_W = 32;
    localparam int BYTE_W   = 8;
    localparam int GROUP_W  = 7;

    localparam logic [2:0]        PREFIX_LAST_IDX = 3'd4;
    localparam logic [BYTE_W-1:0] FIFTH_BYTE_TOP  = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK       = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_FORM       = 8'h80;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_PREFIX = 2'd1,
        ST_BAD_BODY   = 2'd2
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [PREFIX_W-1:0]   length;
    } t_result;

endpackage

/* rtl/lpu8_in_reg.sv */
module lpu8_in_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [lpu8_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_stall,
    input  logic                        i_take,
    output logic                        o_valid,
    output logic [lpu8_pkg::BYTE_W-1:0] o_byte
);
    import lpu8_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // hold the item until the parser takes it
    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

/* rtl/lpu8_parse.sv */
module lpu8_parse #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [lpu8_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_emit,
    output lpu8_pkg::t_result           o_result
);
    import lpu8_pkg::*;

    typedef enum logic {
        PH_PREFIX,
        PH_BODY
    } t_phase;

    t_phase                 r_phase,     n_phase;
    logic [PREFIX_W-1:0]    r_acc,       n_acc;
    logic [2:0]             r_seen,      n_seen;
    logic [LENGTH_BITS-1:0] r_remaining, n_remaining;
    logic [LENGTH_BITS-1:0] r_length,    n_length;
    logic [1:0]             r_cont,      n_cont;
    logic                   r_term,      n_term;
    logic                   r_bad,       n_bad;

    logic [PREFIX_W-1:0]    group_shifted;
    logic [PREFIX_W-1:0]    acc_sum;
    logic [GROUP_W-1:0]     group;

    assign group = i_byte[GROUP_W-1:0];

    always_comb begin
        case (r_seen)
            3'd0:    group_shifted = {{(PREFIX_W-GROUP_W){1'b0}}, group};
            3'd1:    group_shifted = {{(PREFIX_W-GROUP_W-7){1'b0}}, group, 7'b0};
            3'd2:    group_shifted = {{(PREFIX_W-GROUP_W-14){1'b0}}, group, 14'b0};
            3'd3:    group_shifted = {{(PREFIX_W-GROUP_W-21){1'b0}}, group, 21'b0};
            default: group_shifted = {group[3:0], 28'b0};
        endcase
    end

    assign acc_sum = r_acc | group_shifted;

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_seen      = r_seen;
        n_remaining = r_remaining;
        n_length    = r_length;
        n_cont      = r_cont;
        n_term      = r_term;
        n_bad       = r_bad;
        o_emit      = 1'b0;
        o_result    = '{status: ST_OK, length: '0};

        unique case (r_phase)
            PH_PREFIX: begin
                if (r_seen == PREFIX_LAST_IDX && (i_byte & FIFTH_BYTE_TOP) != '0) begin
                    o_emit          = 1'b1;
                    o_result.status = ST_BAD_PREFIX;
                end else if (i_byte[BYTE_W-1] && r_seen != PREFIX_LAST_IDX) begin
                    n_acc  = acc_sum;
                    n_seen = r_seen + 3'd1;
                end else if ((acc_sum >> LENGTH_BITS) != '0) begin
                    o_emit          = 1'b1;
                    o_result.status = ST_BAD_PREFIX;
                end else if (acc_sum == '0) begin
                    o_emit = 1'b1;
                end else begin
                    n_phase     = PH_BODY;
                    n_length    = acc_sum[LENGTH_BITS-1:0];
                    n_remaining = acc_sum[LENGTH_BITS-1:0];
                    n_cont      = 2'd0;
                    n_term      = 1'b0;
                    n_bad       = 1'b0;
                end
            end
            PH_BODY: begin
                if (!r_term && !r_bad) begin
                    if (r_cont != 2'd0) begin
                        if (i_byte == '0 || (i_byte & CONT_MASK) != CONT_FORM) begin
                            n_bad = 1'b1;
                        end else begin
                            n_cont = r_cont - 2'd1;
                        end
                    end else if (i_byte == '0) begin
                        n_term = 1'b1;
                    end else if (!i_byte[7]) begin
                        n_cont = 2'd0;
                    end else if (i_byte[7:5] == 3'b110) begin
                        n_cont = 2'd1;
                    end else if (i_byte[7:4] == 4'b1110) begin
                        n_cont = 2'd2;
                    end else if (i_byte[7:3] == 5'b11110) begin
                        n_cont = 2'd3;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                n_remaining = r_remaining - 1'b1;
                if (n_remaining == '0) begin
                    o_emit          = 1'b1;
                    o_result.length = PREFIX_W'(r_length);
                    // a sequence cut short by the end of the body is invalid
                    if (n_bad || (!n_term && n_cont != 2'd0)) begin
                        o_result.status = ST_BAD_BODY;
                    end
                end
            end
            default: begin
                n_phase = PH_PREFIX;
            end
        endcase

        // start over on the next prefix after every result
        if (o_emit) begin
            n_phase     = PH_PREFIX;
            n_acc       = '0;
            n_seen      = 3'd0;
            n_remaining = '0;
            n_cont      = 2'd0;
            n_term      = 1'b0;
            n_bad       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PREFIX;
            r_acc       <= '0;
            r_seen      <= 3'd0;
            r_remaining <= '0;
            r_length    <= '0;
            r_cont      <= 2'd0;
            r_term      <= 1'b0;
            r_bad       <= 1'b0;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_seen      <= n_seen;
            r_remaining <= n_remaining;
            r_length    <= n_length;
            r_cont      <= n_cont;
            r_term      <= n_term;
            r_bad       <= n_bad;
        end
    end

endmodule

/* rtl/lpu8_out_reg.sv */
module lpu8_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lpu8_pkg::t_result i_result,
    output logic              o_ready,
    output logic              o_valid,
    output lpu8_pkg::t_result o_result,
    input  logic              i_stall
);
    import lpu8_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/leb128_prefixed_utf8_string_check.sv */
// channel   | valid      | stall       | payload
// ----------+------------+-------------+---------------------
// byte in   | i_in_valid | o_in_stall  | i_data_byte
// result    | o_out_valid| i_out_stall | o_status, o_length
//
// One byte per cycle when not stalled; the byte that ends the string passes
// the input register, then the state update into the result register.
// The state update between the two registers sets the one-cycle rate.
// Reset (i_rst_n low at a clock edge) returns to the length prefix phase.
// A stalled result holds the byte in the input register; if that register is
// empty, one more byte is taken before o_in_stall rises.
module leb128_prefixed_utf8_string_check #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [lpu8_pkg::BYTE_W-1:0] i_data_byte,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output logic [1:0]                  o_status,
    output logic [31:0]                 o_length,
    input  logic                        i_out_stall
);
    import lpu8_pkg::*;

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_q;
    logic              out_ready;
    logic              take;
    logic              emit;
    t_result           result_d;
    t_result           result_q;

    assign take = byte_valid && out_ready;

    lpu8_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_data_byte),
        .o_stall (o_in_stall),
        .i_take  (take),
        .o_valid (byte_valid),
        .o_byte  (byte_q)
    );

    lpu8_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (byte_q),
        .o_emit   (emit),
        .o_result (result_d)
    );

    lpu8_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && emit),
        .i_result (result_d),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .o_result (result_q),
        .i_stall  (i_out_stall)
    );

    assign o_status = result_q.status;
    assign o_length = result_q.length;

    a_bad_prefix_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_BAD_PREFIX |-> o_length == '0)
        else $error("malformed prefix reported with nonzero length");

    a_length_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_length >> LENGTH_BITS) == '0)
        else $error("length wider than LENGTH_BITS");

    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || !i_out_stall) |-> !o_in_stall)
        else $error("input stalled while result side is free");

    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

endmodule
